>>> src/adcl_pkg.sv
// Shared types, widths and constant tables of the ladder DIP decoder.
// Used by the controller, the datapath and the top level. No dependencies.
package adcl_pkg;

    localparam int SAMPLE_W   = 12;
    localparam int SUM_W      = 20;
    localparam int COUNT_W    = 8;
    localparam int TAKEN_W    = COUNT_W + 1;
    localparam int CODE_W     = 4;
    localparam int LEVEL_W    = 12;
    localparam int TABLE_SIZE = 16;
    localparam int IDX_W      = $clog2(TABLE_SIZE);
    localparam int DIV_STEPS  = SUM_W;
    localparam int STEP_W     = $clog2(DIV_STEPS);

    localparam logic [COUNT_W-1:0] COUNT_RESET = 8'd100;

    localparam int DEF_LEVEL_COUNT = 16;
    localparam int DEF_SAMPLE_BITS = 12;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accumulate;
        logic div_step;
        logic search_step;
        logic load_out;
    } adcl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic decode_due;
        logic div_last;
        logic search_last;
    } adcl_status_t;

    // Ideal ladder voltage of each rank, in converter counts.
    function automatic logic [LEVEL_W-1:0] ideal_level(input logic [IDX_W-1:0] idx);
        logic [LEVEL_W-1:0] lvl;
        case (idx)
            4'd0:    lvl = 12'd4095;
            4'd1:    lvl = 12'd3723;
            4'd2:    lvl = 12'd3374;
            4'd3:    lvl = 12'd3117;
            4'd4:    lvl = 12'd2786;
            4'd5:    lvl = 12'd2608;
            4'd6:    lvl = 12'd2432;
            4'd7:    lvl = 12'd2296;
            4'd8:    lvl = 12'd2048;
            4'd9:    lvl = 12'd1950;
            4'd10:   lvl = 12'd1850;
            4'd11:   lvl = 12'd1770;
            4'd12:   lvl = 12'd1658;
            4'd13:   lvl = 12'd1593;
            4'd14:   lvl = 12'd1526;
            4'd15:   lvl = 12'd1471;
            default: lvl = 12'd0;
        endcase
        return lvl;
    endfunction

    // Switch setting of each rank, bit 3 down to bit 0 as B3..B0.
    function automatic logic [CODE_W-1:0] rank_to_code(input logic [IDX_W-1:0] idx);
        logic [CODE_W-1:0] code;
        case (idx)
            4'd0:    code = 4'h0;
            4'd1:    code = 4'h8;
            4'd2:    code = 4'h4;
            4'd3:    code = 4'hC;
            4'd4:    code = 4'h2;
            4'd5:    code = 4'hA;
            4'd6:    code = 4'h6;
            4'd7:    code = 4'hE;
            4'd8:    code = 4'h1;
            4'd9:    code = 4'h9;
            4'd10:   code = 4'h5;
            4'd11:   code = 4'hD;
            4'd12:   code = 4'h3;
            4'd13:   code = 4'hB;
            4'd14:   code = 4'h7;
            4'd15:   code = 4'hF;
            default: code = 4'h0;
        endcase
        return code;
    endfunction

endpackage

>>> src/adcl_datapath.sv
// Datapath of the ladder DIP decoder: accumulator, restoring divider,
// nearest-level search and result registers. Depends on adcl_pkg.
module adcl_datapath
    import adcl_pkg::*;
#(
    parameter int LEVEL_COUNT = DEF_LEVEL_COUNT,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  adcl_cmd_t           cmd,
    output adcl_status_t        status,
    input  logic                cfg_we,
    input  logic [COUNT_W-1:0]  cfg_count,
    input  logic [SAMPLE_W-1:0] adc_sample,
    output logic [CODE_W-1:0]   switch_code,
    output logic [SAMPLE_W-1:0] averaged_level,
    output logic [LEVEL_W-1:0]  match_error
);

    localparam int USED_BITS = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MASK =
        SAMPLE_W'((33'd1 << USED_BITS) - 33'd1);
    localparam int SEARCH_LEN = (LEVEL_COUNT < TABLE_SIZE) ? LEVEL_COUNT : TABLE_SIZE;
    localparam logic [IDX_W-1:0]  SEARCH_LAST = IDX_W'(SEARCH_LEN - 1);
    localparam logic [STEP_W-1:0] STEP_LAST   = STEP_W'(DIV_STEPS - 1);

    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [COUNT_W-1:0] cnt_reg, cnt_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;

    logic [TAKEN_W-1:0] divisor_reg, divisor_next;
    logic [TAKEN_W-1:0] rem_reg, rem_next;
    logic [SUM_W-1:0]   quo_reg, quo_next;
    logic [SUM_W-1:0]   best_err_reg, best_err_next;
    logic [IDX_W-1:0]   best_idx_reg, best_idx_next;
    logic [CODE_W-1:0]  code_reg, code_next;
    logic [SAMPLE_W-1:0] avg_reg, avg_next;
    logic [LEVEL_W-1:0] err_reg, err_next;

    logic [SUM_W-1:0]   sum_add;
    logic [TAKEN_W-1:0] taken;
    logic [TAKEN_W:0]   rem_shift;
    logic               rem_ge;
    logic [SUM_W-1:0]   level_ext;
    logic [SUM_W-1:0]   cur_err;
    logic               take_new;

    assign sum_add = sum_reg + SUM_W'(adc_sample & SAMPLE_MASK);
    assign taken   = {1'b0, cnt_reg} + TAKEN_W'(1);

    assign rem_shift = {rem_reg, quo_reg[SUM_W-1]};
    assign rem_ge    = (rem_shift >= {1'b0, divisor_reg});

    assign level_ext = SUM_W'(ideal_level(idx_reg));
    assign cur_err   = (quo_reg >= level_ext) ? (quo_reg - level_ext)
                                              : (level_ext - quo_reg);
    // Strict compare keeps the lowest rank on a tie.
    assign take_new  = (idx_reg == '0) || (cur_err < best_err_reg);

    assign status.decode_due  = (taken >= {1'b0, count_reg});
    assign status.div_last    = (step_reg == STEP_LAST);
    assign status.search_last = (idx_reg == SEARCH_LAST);

    always_comb
    begin
        sum_next      = sum_reg;
        cnt_next      = cnt_reg;
        count_next    = cfg_we ? cfg_count : count_reg;
        step_next     = step_reg;
        idx_next      = idx_reg;
        divisor_next  = divisor_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        best_err_next = best_err_reg;
        best_idx_next = best_idx_reg;
        code_next     = code_reg;
        avg_next      = avg_reg;
        err_next      = err_reg;

        if (cmd.accumulate)
        begin
            if (status.decode_due)
            begin
                sum_next     = '0;
                cnt_next     = '0;
                divisor_next = taken;
                quo_next     = sum_add;
                rem_next     = '0;
                step_next    = '0;
                idx_next     = '0;
            end
            else
            begin
                sum_next = sum_add;
                cnt_next = taken[COUNT_W-1:0];
            end
        end

        if (cmd.div_step)
        begin
            rem_next  = rem_ge ? TAKEN_W'(rem_shift - {1'b0, divisor_reg})
                               : rem_shift[TAKEN_W-1:0];
            quo_next  = {quo_reg[SUM_W-2:0], rem_ge};
            step_next = step_reg + STEP_W'(1);
        end

        if (cmd.search_step)
        begin
            if (take_new)
            begin
                best_err_next = cur_err;
                best_idx_next = idx_reg;
            end
            idx_next = idx_reg + IDX_W'(1);
        end

        if (cmd.load_out)
        begin
            code_next = rank_to_code(best_idx_reg);
            avg_next  = quo_reg[SAMPLE_W-1:0];
            err_next  = best_err_reg[LEVEL_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            cnt_reg   <= '0;
            count_reg <= COUNT_RESET;
            step_reg  <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            sum_reg   <= sum_next;
            cnt_reg   <= cnt_next;
            count_reg <= count_next;
            step_reg  <= step_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        divisor_reg  <= divisor_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        best_err_reg <= best_err_next;
        best_idx_reg <= best_idx_next;
        code_reg     <= code_next;
        avg_reg      <= avg_next;
        err_reg      <= err_next;
    end

    assign switch_code    = code_reg;
    assign averaged_level = avg_reg;
    assign match_error    = err_reg;

endmodule

>>> src/adcl_ctrl.sv
// Controller of the ladder DIP decoder: sequences accumulate, divide,
// search and result hand-off, and owns the handshakes. Depends on adcl_pkg.
module adcl_ctrl
    import adcl_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    output logic         out_valid,
    input  logic         out_ready,
    input  adcl_status_t status,
    output adcl_cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_DIV    = 4'b0010,
        S_SEARCH = 4'b0100,
        S_OUT    = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        cmd.accumulate  = 1'b0;
        cmd.div_step    = 1'b0;
        cmd.search_step = 1'b0;
        cmd.load_out    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accumulate = 1'b1;
                    if (status.decode_due)
                    begin
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                cmd.search_step = 1'b1;
                if (status.search_last)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // A new result is never written over one that is still waiting.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || out_ready))
        else $error("result register loaded while a result was pending");

    // A sample that completes the average starts the divider next cycle.
    a_decode_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accumulate && status.decode_due) |=> (state_reg == S_DIV))
        else $error("decode did not start the divider");

    // The search follows right after the last divide step.
    a_div_to_search: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && status.div_last) |=> (state_reg == S_SEARCH))
        else $error("search did not follow the divider");

endmodule

>>> src/adc_ladder_dip_decoder_top.sv
// Top level of the resistor-ladder DIP switch decoder.
// Instantiates adcl_ctrl and adcl_datapath; depends on adcl_pkg.
//
// Usage:
//   Converter samples arrive on the input channel (in_valid, in_ready,
//   adc_sample). Each transaction adds one sample to a 20-bit running sum.
//   When the number of samples set by averaging_count has been collected,
//   the block divides the sum by that count, finds the nearest of the fixed
//   ladder levels (lowest rank wins a tie) and emits one transaction on the
//   output channel (out_valid, out_ready, switch_code, averaged_level,
//   match_error). A count of zero behaves like one.
//   A sample that does not complete an average is taken and leaves the block idle, so
//   in_ready is high again on the next cycle. A completing sample starts a
//   decode: a one-bit-per-cycle restoring divider, a search over the
//   ladder levels (16 with the default table), and the load of the result
//   register, after which out_valid rises.
//   in_ready stays low during a decode.
//   If the receiver stalls, the result stays in its register and the block
//   keeps accepting samples; only a following decode waits for the register
//   to drain before it loads its result.
//   The configuration channel (cfg_valid, cfg_ready, averaging_count) is
//   always ready and writes the count; write it only while the block is idle.
//   Reset clears the sum and the sample counter, drops out_valid and sets
//   the count to 100.
module adc_ladder_dip_decoder_top
    import adcl_pkg::*;
#(
    parameter int LEVEL_COUNT = DEF_LEVEL_COUNT,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [SAMPLE_W-1:0] adc_sample,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [CODE_W-1:0]   switch_code,
    output logic [SAMPLE_W-1:0] averaged_level,
    output logic [LEVEL_W-1:0]  match_error,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [COUNT_W-1:0]  averaging_count
);

    adcl_cmd_t    cmd;
    adcl_status_t status;

    // The count register takes a write in any cycle.
    assign cfg_ready = 1'b1;

    adcl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    adcl_datapath #(
        .LEVEL_COUNT (LEVEL_COUNT),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg_we         (cfg_valid & cfg_ready),
        .cfg_count      (averaging_count),
        .adc_sample     (adc_sample),
        .switch_code    (switch_code),
        .averaged_level (averaged_level),
        .match_error    (match_error)
    );

endmodule
